/* rtl/multichannel_biquad_filter_macros.svh */
// Assertion macros for the multichannel biquad filter.
// Included by multichannel_biquad_filter.sv, the RTL file that carries the concurrent checks; no other dependencies.
`ifndef MULTICHANNEL_BIQUAD_FILTER_MACROS_SVH
`define MULTICHANNEL_BIQUAD_FILTER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Consequent must hold in the same cycle as the antecedent
`define MBQ_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("multichannel_biquad_filter: check failed");

// Consequent must hold in the cycle after the antecedent
`define MBQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("multichannel_biquad_filter: check failed");

`else

`define MBQ_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define MBQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/mbq_pkg.sv */
// Shared types, constants and the microcode program of the biquad filter.
// No dependencies; imported by every module of the block.
package mbq_pkg;

    localparam int COEF_W    = 32;
    localparam int DELAY_W   = 32;
    localparam int CH_W      = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;
    localparam int STEP_W    = 4;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_B0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_A2 = 3'd4;

    localparam logic signed [COEF_W-1:0] B0_RESET = 32'sh1000_0000;

    typedef logic [STEP_W-1:0] t_step;

    // Program addresses
    localparam t_step ST_IDLE   = 4'd0;
    localparam t_step ST_LOAD   = 4'd1;
    localparam t_step ST_FB1    = 4'd2;
    localparam t_step ST_FB2    = 4'd3;
    localparam t_step ST_FF1    = 4'd4;
    localparam t_step ST_WLATCH = 4'd5;
    localparam t_step ST_WRITE  = 4'd6;
    localparam t_step ST_FINAL  = 4'd7;
    localparam t_step ST_OUT    = 4'd8;

    // Multiplier operand pair
    typedef enum logic [2:0] {
        MS_NONE,
        MS_A1_Z1,
        MS_A2_Z2,
        MS_B0_W,
        MS_B1_Z1,
        MS_B2_Z2
    } t_msel;

    // Accumulator operation
    typedef enum logic [2:0] {
        AO_HOLD,
        AO_LOAD_X,
        AO_SUB,
        AO_ADD,
        AO_LOAD_RND_ADD
    } t_aop;

    // Sequencing condition
    typedef enum logic [1:0] {
        JC_NEXT,
        JC_WAIT_IN,
        JC_WAIT_OUT
    } t_jcond;

    typedef struct packed {
        logic   ready;
        logic   load_z;
        logic   latch_w;
        logic   mem_wr;
        logic   out_load;
        t_msel  msel;
        t_aop   aop;
        t_jcond jc;
        t_step  target;
    } t_uword;

    typedef struct packed {
        logic signed [COEF_W-1:0] b0;
        logic signed [COEF_W-1:0] b1;
        logic signed [COEF_W-1:0] b2;
        logic signed [COEF_W-1:0] a1;
        logic signed [COEF_W-1:0] a2;
    } t_coefs;

    // Control store: one word per step
    function automatic t_uword mbq_ucode(input t_step step);
        t_uword uw;
        uw = '{ready: 1'b0, load_z: 1'b0, latch_w: 1'b0, mem_wr: 1'b0, out_load: 1'b0,
               msel: MS_NONE, aop: AO_HOLD, jc: JC_NEXT, target: ST_IDLE};
        case (step)
            ST_IDLE: begin
                uw.ready = 1'b1;
                uw.jc    = JC_WAIT_IN;
            end
            ST_LOAD: begin
                uw.load_z = 1'b1;
                uw.aop    = AO_LOAD_X;
            end
            ST_FB1: begin
                uw.msel = MS_A1_Z1;
            end
            ST_FB2: begin
                uw.msel = MS_A2_Z2;
                uw.aop  = AO_SUB;
            end
            ST_FF1: begin
                uw.msel = MS_B1_Z1;
                uw.aop  = AO_SUB;
            end
            ST_WLATCH: begin
                uw.msel    = MS_B2_Z2;
                uw.latch_w = 1'b1;
                uw.aop     = AO_LOAD_RND_ADD;
            end
            ST_WRITE: begin
                uw.msel   = MS_B0_W;
                uw.aop    = AO_ADD;
                uw.mem_wr = 1'b1;
            end
            ST_FINAL: begin
                uw.aop = AO_ADD;
            end
            ST_OUT: begin
                uw.out_load = 1'b1;
                uw.jc       = JC_WAIT_OUT;
                uw.target   = ST_IDLE;
            end
            default: begin
                uw.jc     = JC_WAIT_OUT;
                uw.target = ST_IDLE;
            end
        endcase
        return uw;
    endfunction

endpackage

/* rtl/mbq_sequencer.sv */
// Microcode sequencer: step counter, control store lookup and jumps.
// Depends on mbq_pkg for the control word and the program.
module mbq_sequencer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic           i_out_free,
    output mbq_pkg::t_uword o_uword,
    output mbq_pkg::t_step  o_step
);
    import mbq_pkg::*;

    t_step  r_step;
    t_step  n_step;
    t_uword uw;

    // Fetch the control word of the current step
    always_comb begin
        uw = mbq_ucode(r_step);
    end

    // Advance, hold or jump
    always_comb begin
        n_step = r_step;
        case (uw.jc)
            JC_NEXT:     n_step = r_step + t_step'(1);
            JC_WAIT_IN:  n_step = i_accept ? r_step + t_step'(1) : r_step;
            JC_WAIT_OUT: n_step = i_out_free ? uw.target : r_step;
            default:     n_step = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_uword = uw;
    assign o_step  = r_step;

endmodule

/* rtl/mbq_state_ram.sv */
// Per-channel delay word store: one row {z1, z2} per channel, registered read.
// Depends on mbq_pkg; row valid bits make unwritten rows read as zero.
module mbq_state_ram #(
    parameter int DEPTH = 8,
    parameter int ROW_W = 3
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [ROW_W-1:0]                 i_rd_addr,
    input  logic                             i_wr_en,
    input  logic [ROW_W-1:0]                 i_wr_addr,
    input  logic [2*mbq_pkg::DELAY_W-1:0]    i_wr_data,
    output logic [2*mbq_pkg::DELAY_W-1:0]    o_rd_data
);
    import mbq_pkg::*;

    logic [2*DELAY_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]     r_valid;
    logic [2*DELAY_W-1:0] r_rd_data;
    logic                 r_rd_valid;

    // Storage array: write one row, read one row
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    // Row valid bits, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    // Unwritten rows read as zero
    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

/* rtl/mbq_datapath.sv */
// Shared multiplier, wide accumulator, rounding and saturation of the biquad.
// Depends on mbq_pkg; driven step by step by the sequencer's control word.
module mbq_datapath #(
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 28
) (
    input  logic                                i_clk,
    input  mbq_pkg::t_uword                     i_uword,
    input  logic                                i_accept,
    input  logic signed [SAMPLE_BITS-1:0]       i_sample,
    input  mbq_pkg::t_coefs                     i_coefs,
    input  logic [2*mbq_pkg::DELAY_W-1:0]       i_rd_data,
    output logic [2*mbq_pkg::DELAY_W-1:0]       o_wr_data,
    output logic signed [SAMPLE_BITS-1:0]       o_y
);
    import mbq_pkg::*;

    localparam int PROD_W = COEF_W + DELAY_W;
    localparam int ACC_W  = PROD_W + 2;
    localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) << (COEF_FRAC_BITS - 1);

    logic signed [SAMPLE_BITS-1:0] r_x;
    logic signed [DELAY_W-1:0]     r_z1;
    logic signed [DELAY_W-1:0]     r_z2;
    logic signed [DELAY_W-1:0]     r_w;
    logic signed [PROD_W-1:0]      r_prod;
    logic signed [ACC_W-1:0]       r_acc;
    logic signed [ACC_W-1:0]       n_acc;

    logic signed [COEF_W-1:0]      op_a;
    logic signed [DELAY_W-1:0]     op_b;
    logic signed [ACC_W-1:0]       prod_ext;
    logic signed [ACC_W-1:0]       q;
    logic [ACC_W-DELAY_W:0]        hi_w;
    logic [ACC_W-SAMPLE_BITS:0]    hi_y;
    logic signed [DELAY_W-1:0]     w_sat;
    logic signed [SAMPLE_BITS-1:0] y_sat;

    // Capture the sample and the channel's delay words
    always_ff @(posedge i_clk) begin
        if (i_uword.ready && i_accept) begin
            r_x <= i_sample;
        end
        if (i_uword.load_z) begin
            r_z1 <= i_rd_data[2*DELAY_W-1:DELAY_W];
            r_z2 <= i_rd_data[DELAY_W-1:0];
        end
        if (i_uword.latch_w) begin
            r_w <= w_sat;
        end
    end

    // Select the multiplier operands
    always_comb begin
        op_a = i_coefs.b0;
        op_b = r_w;
        case (i_uword.msel)
            MS_A1_Z1: begin
                op_a = i_coefs.a1;
                op_b = r_z1;
            end
            MS_A2_Z2: begin
                op_a = i_coefs.a2;
                op_b = r_z2;
            end
            MS_B0_W: begin
                op_a = i_coefs.b0;
                op_b = r_w;
            end
            MS_B1_Z1: begin
                op_a = i_coefs.b1;
                op_b = r_z1;
            end
            MS_B2_Z2: begin
                op_a = i_coefs.b2;
                op_b = r_z2;
            end
            default: begin
                op_a = i_coefs.b0;
                op_b = r_w;
            end
        endcase
    end

    // Registered product
    always_ff @(posedge i_clk) begin
        r_prod <= op_a * op_b;
    end

    // Accumulate products on top of the scaled sample or the rounding offset
    assign prod_ext = ACC_W'(r_prod);

    always_comb begin
        n_acc = r_acc;
        case (i_uword.aop)
            AO_HOLD:         n_acc = r_acc;
            AO_LOAD_X:       n_acc = (ACC_W'(r_x) <<< COEF_FRAC_BITS) + RND;
            AO_SUB:          n_acc = r_acc - prod_ext;
            AO_ADD:          n_acc = r_acc + prod_ext;
            AO_LOAD_RND_ADD: n_acc = RND + prod_ext;
            default:         n_acc = r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    // Drop the fraction bits (floor) and saturate
    assign q    = r_acc >>> COEF_FRAC_BITS;
    assign hi_w = q[ACC_W-1:DELAY_W-1];
    assign hi_y = q[ACC_W-1:SAMPLE_BITS-1];

    always_comb begin
        if ((&hi_w) || !(|hi_w)) begin
            w_sat = q[DELAY_W-1:0];
        end else if (q[ACC_W-1]) begin
            w_sat = {1'b1, {(DELAY_W-1){1'b0}}};
        end else begin
            w_sat = {1'b0, {(DELAY_W-1){1'b1}}};
        end
    end

    always_comb begin
        if ((&hi_y) || !(|hi_y)) begin
            y_sat = q[SAMPLE_BITS-1:0];
        end else if (q[ACC_W-1]) begin
            y_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
            y_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    end

    // New row: z1 <- w, z2 <- old z1
    assign o_wr_data = {r_w, r_z1};
    assign o_y       = y_sat;

endmodule

/* rtl/multichannel_biquad_filter.sv */
// Multichannel direct form II biquad: top level with handshakes and registers.
// Depends on mbq_pkg, the macros header, mbq_sequencer, mbq_state_ram, mbq_datapath.
//
// Use: requests arrive on the input channel (i_in_valid / o_in_ready) with a
// channel number and a signed sample; each request yields one filtered sample
// with the same channel number on the output channel (o_out_valid / i_out_ready).
// Coefficients b0, b1, b2, a1, a2 are written through i_cfg_we / i_cfg_addr /
// i_cfg_wdata at indexes 0 to 4 while the block is idle; other indexes are ignored.
// After the accepting edge the steps LOAD, FB1, FB2, FF1, WLATCH, WRITE, FINAL and
// OUT follow, and OUT loads the result into the output register. The microcode runs
// the five products of a sample one after another through a single multiplier, and
// takes a new request only in its idle step. The output register lets a new request
// in while a result waits; if the receiver stalls, the next request runs up to its last
// step and holds there until the output register frees up.
// Reset (synchronous, active low) restores the coefficient defaults (b0 = 1.0,
// others 0), clears every channel's delay words through row valid bits and
// empties the output register; there is no clearing pass.
module multichannel_biquad_filter #(
    parameter int MAX_CHANNELS   = 8,
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 28
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [mbq_pkg::CH_W-1:0]           i_channel_in,
    input  logic signed [SAMPLE_BITS-1:0]      i_sample_in,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [mbq_pkg::CH_W-1:0]           o_channel_out,
    output logic signed [SAMPLE_BITS-1:0]      o_sample_out,
    input  logic                               i_cfg_we,
    input  logic [mbq_pkg::CFG_IDX_W-1:0]      i_cfg_addr,
    input  logic [mbq_pkg::CFG_W-1:0]          i_cfg_wdata
);
    import mbq_pkg::*;
    `include "multichannel_biquad_filter_macros.svh"

    localparam int ROW_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    t_coefs                 r_coefs;
    logic [CH_W-1:0]        r_ch;
    logic [ROW_W-1:0]       r_row;
    logic                   r_out_valid;
    logic [CH_W-1:0]        r_out_ch;
    logic signed [SAMPLE_BITS-1:0] r_out_sample;

    t_uword                 uw;
    t_step                  step;
    logic                   in_accept;
    logic                   out_free;
    logic                   out_load;
    logic [CH_W-1:0]        ch_mod;
    logic [ROW_W+CH_W-1:0]  row_wide;
    logic [ROW_W-1:0]       in_row;
    logic [2*DELAY_W-1:0]   rd_data;
    logic [2*DELAY_W-1:0]   wr_data;
    logic signed [SAMPLE_BITS-1:0] y;

    assign o_in_ready = uw.ready;
    assign in_accept  = i_in_valid && uw.ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign out_load   = uw.out_load && out_free;

    // Fold the channel number onto the available rows
    always_comb begin
        ch_mod = i_channel_in;
        for (int k = 0; k < (1 << CH_W); k++) begin
            if (int'(ch_mod) >= MAX_CHANNELS) begin
                ch_mod = ch_mod - CH_W'(MAX_CHANNELS);
            end
        end
        row_wide = {{ROW_W{1'b0}}, ch_mod};
        in_row   = row_wide[ROW_W-1:0];
    end

    // Coefficient registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs.b0 <= B0_RESET;
            r_coefs.b1 <= '0;
            r_coefs.b2 <= '0;
            r_coefs.a1 <= '0;
            r_coefs.a2 <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_B0:  r_coefs.b0 <= i_cfg_wdata;
                REG_B1:  r_coefs.b1 <= i_cfg_wdata;
                REG_B2:  r_coefs.b2 <= i_cfg_wdata;
                REG_A1:  r_coefs.a1 <= i_cfg_wdata;
                REG_A2:  r_coefs.a2 <= i_cfg_wdata;
                default: r_coefs    <= r_coefs;
            endcase
        end
    end

    // Hold the request's channel while it is worked on
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_ch  <= i_channel_in;
            r_row <= in_row;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_ch     <= r_ch;
            r_out_sample <= y;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_channel_out = r_out_ch;
    assign o_sample_out  = r_out_sample;

    mbq_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (in_accept),
        .i_out_free (out_free),
        .o_uword    (uw),
        .o_step     (step)
    );

    mbq_state_ram #(
        .DEPTH (MAX_CHANNELS),
        .ROW_W (ROW_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (in_row),
        .i_wr_en   (uw.mem_wr),
        .i_wr_addr (r_row),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

    mbq_datapath #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_uword   (uw),
        .i_accept  (in_accept),
        .i_sample  (i_sample_in),
        .i_coefs   (r_coefs),
        .i_rd_data (rd_data),
        .o_wr_data (wr_data),
        .o_y       (y)
    );

    // A request starts the program; no second request while it runs
    `MBQ_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_accept, !o_in_ready)
    // A result is never written over one still waiting
    `MBQ_ASSERT_IMPLY(a_no_overwrite, i_clk, i_rst_n, out_load, out_free)
    // Loading a result raises the output valid
    `MBQ_ASSERT_NEXT(a_load_shows, i_clk, i_rst_n, out_load, o_out_valid)
    // The delay row is written only in the write step
    `MBQ_ASSERT_IMPLY(a_write_step, i_clk, i_rst_n, uw.mem_wr, step == ST_WRITE)

endmodule

/* sim/mbq_filter_checker.sv */
`timescale 1ns / 1ps
// Watches both channels and the coefficient port of the biquad filter, keeps its own
// copy of the coefficients and per-channel delay words, and scores every filtered sample.
// Depends on mbq_pkg for widths, register indexes and the coefficient record.
module mbq_filter_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic [mbq_pkg::CH_W-1:0]      i_channel_in,
    input  logic signed [23:0]            i_sample_in,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [mbq_pkg::CH_W-1:0]      i_channel_out,
    input  logic signed [23:0]            i_sample_out,
    input  logic                          i_cfg_we,
    input  logic [mbq_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [mbq_pkg::CFG_W-1:0]     i_cfg_wdata,
    output int                            o_fail_count,
    output int                            o_pending_count
);
    import mbq_pkg::*;

    localparam int SAMPLE_W     = 24;
    localparam int CHANNELS     = 8;
    localparam int FRAC         = 28;
    localparam int ACC_W        = 66;
    localparam int MAX_REPORTS  = 10;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = 2 ** (FRAC - 1);
    localparam logic signed [ACC_W-1:0] DELAY_HI   = (66'sd1 <<< (DELAY_W - 1)) - 66'sd1;
    localparam logic signed [ACC_W-1:0] DELAY_LO   = -(66'sd1 <<< (DELAY_W - 1));
    localparam logic signed [ACC_W-1:0] SAMPLE_HI  = (66'sd1 <<< (SAMPLE_W - 1)) - 66'sd1;
    localparam logic signed [ACC_W-1:0] SAMPLE_LO  = -(66'sd1 <<< (SAMPLE_W - 1));

    typedef struct {
        logic [CH_W-1:0]            ch;
        logic signed [SAMPLE_W-1:0] sample;
    } t_filtered;

    t_coefs                    coefs;
    logic signed [DELAY_W-1:0] delay_one [CHANNELS];
    logic signed [DELAY_W-1:0] delay_two [CHANNELS];
    t_filtered                 awaited_samples [$];
    t_filtered                 head;
    t_filtered                 fresh;
    int                        failures = 0;

    assign o_fail_count = failures;

    // Divide by 2^FRAC, rounding half up
    function automatic logic signed [ACC_W-1:0] round_frac(input logic signed [ACC_W-1:0] v);
        return (v + ROUND_HALF) >>> FRAC;
    endfunction

    function automatic logic signed [ACC_W-1:0] clamp(input logic signed [ACC_W-1:0] v,
                                                       input logic signed [ACC_W-1:0] hi,
                                                       input logic signed [ACC_W-1:0] lo);
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // Run one sample through the section and shift that channel's delay words
    function automatic logic signed [SAMPLE_W-1:0] filter_next_sample(
        input logic [CH_W-1:0] ch, input logic signed [SAMPLE_W-1:0] x);
        logic signed [ACC_W-1:0] z1, z2, w, acc;
        logic signed [ACC_W-1:0] k_b0, k_b1, k_b2, k_a1, k_a2;
        z1   = delay_one[ch % CHANNELS];
        z2   = delay_two[ch % CHANNELS];
        k_b0 = coefs.b0;
        k_b1 = coefs.b1;
        k_b2 = coefs.b2;
        k_a1 = coefs.a1;
        k_a2 = coefs.a2;
        acc  = x;
        acc  = (acc <<< FRAC) - k_a1 * z1 - k_a2 * z2;
        w    = clamp(round_frac(acc), DELAY_HI, DELAY_LO);
        acc  = k_b0 * w + k_b1 * z1 + k_b2 * z2;
        delay_two[ch % CHANNELS] = delay_one[ch % CHANNELS];
        delay_one[ch % CHANNELS] = DELAY_W'(w);
        return SAMPLE_W'(clamp(round_frac(acc), SAMPLE_HI, SAMPLE_LO));
    endfunction

    task automatic note_failure(input string msg);
        failures++;
        if (failures <= MAX_REPORTS) $display("mbq_checker: %s", msg);
    endtask

    // Track coefficient writes, score results, then predict the newly accepted request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            coefs = '{b0: B0_RESET, b1: '0, b2: '0, a1: '0, a2: '0};
            for (int c = 0; c < CHANNELS; c++) begin
                delay_one[c] = '0;
                delay_two[c] = '0;
            end
            awaited_samples.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_B0:  coefs.b0 = i_cfg_wdata;
                    REG_B1:  coefs.b1 = i_cfg_wdata;
                    REG_B2:  coefs.b2 = i_cfg_wdata;
                    REG_A1:  coefs.a1 = i_cfg_wdata;
                    REG_A2:  coefs.a2 = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (awaited_samples.size() == 0) begin
                    note_failure($sformatf("unexpected result ch %0d sample %0d",
                                           i_channel_out, i_sample_out));
                end else begin
                    head = awaited_samples.pop_front();
                    if (head.ch !== i_channel_out || head.sample !== i_sample_out)
                        note_failure($sformatf(
                            "mismatch: got ch %0d sample %0d, expected ch %0d sample %0d",
                            i_channel_out, i_sample_out, head.ch, head.sample));
                end
            end
            if (i_in_valid && i_in_ready) begin
                fresh.ch     = i_channel_in;
                fresh.sample = filter_next_sample(i_channel_in, i_sample_in);
                awaited_samples.push_back(fresh);
            end
        end
        o_pending_count <= awaited_samples.size();
    end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// Top of the biquad filter testbench: clock, reset, coefficient phases, request
// stimulus with bursts and gaps, output back-pressure and the verdict.
// Depends on mbq_pkg, multichannel_biquad_filter and mbq_filter_checker.
module tb_top;
    import mbq_pkg::*;

    localparam int SAMPLE_W      = 24;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 235;
    localparam int LONG_HOLD     = 300;
    localparam int DRAIN_CYCLES  = 16;

    localparam logic signed [COEF_W-1:0]   COEF_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [COEF_W-1:0]   COEF_MIN   = 32'sh8000_0000;
    localparam logic signed [COEF_W-1:0]   COEF_HALF  = 32'sh0800_0000;
    localparam logic signed [COEF_W-1:0]   COEF_M_ONE = -32'sh1000_0000;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7F_FFFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh80_0000;

    typedef enum int {MIX_STABLE, MIX_FULL, MIX_CORNER, MIX_SMALL} t_coef_mix;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        i_in_valid;
    logic                        o_in_ready;
    logic [CH_W-1:0]             i_channel_in;
    logic signed [SAMPLE_W-1:0]  i_sample_in;
    logic                        o_out_valid;
    logic                        i_out_ready;
    logic [CH_W-1:0]             o_channel_out;
    logic signed [SAMPLE_W-1:0]  o_sample_out;
    logic                        i_cfg_we;
    logic [CFG_IDX_W-1:0]        i_cfg_addr;
    logic [CFG_W-1:0]            i_cfg_wdata;
    int                          fail_count;
    int                          pending_count;
    int                          rx_hold_cycles = 0;

    always #10 i_clk = ~i_clk;

    multichannel_biquad_filter DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_channel_in  (i_channel_in),
        .i_sample_in   (i_sample_in),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_channel_out (o_channel_out),
        .o_sample_out  (o_sample_out),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    mbq_filter_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_channel_in    (i_channel_in),
        .i_sample_in     (i_sample_in),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_channel_out   (o_channel_out),
        .i_sample_out    (o_sample_out),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count)
    );

    // Offer one request and hold it until accepted
    task automatic send_request(input logic [CH_W-1:0] ch, input logic signed [SAMPLE_W-1:0] s);
        i_in_valid   <= 1'b1;
        i_channel_in <= ch;
        i_sample_in  <= s;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Drop valid and hold off until every filtered sample has come back
    task automatic wait_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
    endtask

    // Write all five coefficients back to back, optionally followed by stray indexes
    task automatic load_coefs(input t_coefs c, input bit with_stray);
        for (int k = 0; k < 5; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_addr  <= CFG_IDX_W'(REG_B0 + k);
            i_cfg_wdata <= CFG_W'(c >> (COEF_W * (4 - k)));
            @(posedge i_clk);
        end
        if (with_stray) begin
            for (int k = REG_A2 + 1; k < 2 ** CFG_IDX_W; k++) begin
                i_cfg_we    <= 1'b1;
                i_cfg_addr  <= CFG_IDX_W'(k);
                i_cfg_wdata <= $urandom;
                @(posedge i_clk);
            end
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic signed [COEF_W-1:0] pick_corner();
        case ($urandom_range(0, 4))
            0:       return COEF_MAX;
            1:       return COEF_MIN;
            2:       return '0;
            3:       return B0_RESET;
            default: return COEF_M_ONE;
        endcase
    endfunction

    function automatic t_coefs pick_coefs(input t_coef_mix mix);
        t_coefs c;
        int     a2, a1_lim;
        case (mix)
            MIX_STABLE: begin
                // keep the poles inside the unit circle: |a2| < 0.9, |a1| < 0.95 (1 + a2)
                a2     = int'($urandom_range(0, 483183820)) - 241591910;
                a1_lim = (268435456 + a2) / 20 * 19;
                c.a2   = a2;
                c.a1   = int'($urandom_range(0, 2 * a1_lim)) - a1_lim;
                c.b0   = int'($urandom_range(0, 1 << 28)) - (1 << 27);
                c.b1   = int'($urandom_range(0, 1 << 28)) - (1 << 27);
                c.b2   = int'($urandom_range(0, 1 << 28)) - (1 << 27);
            end
            MIX_FULL: begin
                c = {$urandom, $urandom, $urandom, $urandom, $urandom};
            end
            MIX_CORNER: begin
                c = {pick_corner(), pick_corner(), pick_corner(), pick_corner(), pick_corner()};
            end
            default: begin
                c.b0 = int'($urandom_range(0, 1 << 27)) - (1 << 26);
                c.b1 = int'($urandom_range(0, 1 << 27)) - (1 << 26);
                c.b2 = int'($urandom_range(0, 1 << 27)) - (1 << 26);
                c.a1 = int'($urandom_range(0, 1 << 27)) - (1 << 26);
                c.a2 = int'($urandom_range(0, 1 << 27)) - (1 << 26);
            end
        endcase
        return c;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return SAMPLE_W'(int'($urandom_range(0, 512)) - 256);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Send random requests in bursts with random gaps, then wait for the tail
    task automatic run_phase(input int n_items);
        int sent, burst, gap;
        sent = 0;
        while (sent < n_items) begin
            burst = $urandom_range(1, 24);
            if ($urandom_range(0, 9) == 0) burst = 80;
            for (int k = 0; k < burst && sent < n_items; k++) begin
                send_request(CH_W'($urandom_range(0, 7)), pick_sample());
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        wait_results();
    endtask

    // Receiver: random stall patterns, plus a long hold-off on request
    initial begin : receiver
        int mode, span;
        forever begin
            if (rx_hold_cycles > 0) begin
                span           = rx_hold_cycles;
                rx_hold_cycles = 0;
                i_out_ready <= 1'b0;
                repeat (span) @(posedge i_clk);
            end else begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(4, 60);
                for (int k = 0; k < span; k++) begin
                    case (mode)
                        0:       i_out_ready <= 1'b1;
                        1:       i_out_ready <= $urandom_range(0, 1);
                        2:       i_out_ready <= (k % 4) != 0;
                        default: i_out_ready <= (k % 7) < 2;
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    // Stimulus and verdict
    initial begin : stimulus
        t_coefs c;
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_channel_in <= '0;
        i_sample_in  <= '0;
        i_cfg_we     <= 1'b0;
        i_cfg_addr   <= '0;
        i_cfg_wdata  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset coefficients: pass-through on every channel, sample extremes
        send_request(3'd0, SAMPLE_MAX);
        send_request(3'd1, SAMPLE_MIN);
        send_request(3'd2, '0);
        send_request(3'd3, 24'sd1);
        send_request(3'd4, -24'sd1);
        send_request(3'd5, 24'sh2A_AAAA);
        send_request(3'd6, 24'sh55_5555);
        send_request(3'd7, SAMPLE_MAX);
        send_request(3'd0, SAMPLE_MIN);
        wait_results();

        // All coefficients at their maximum: delay word and output saturation
        c = '{b0: COEF_MAX, b1: COEF_MAX, b2: COEF_MAX, a1: COEF_MAX, a2: COEF_MAX};
        load_coefs(c, 1'b0);
        send_request(3'd0, SAMPLE_MAX);
        send_request(3'd0, SAMPLE_MIN);
        send_request(3'd0, SAMPLE_MAX);
        send_request(3'd1, SAMPLE_MIN);
        send_request(3'd1, SAMPLE_MIN);
        wait_results();

        // All at their minimum, with writes to unused indexes that must be dropped
        c = '{b0: COEF_MIN, b1: COEF_MIN, b2: COEF_MIN, a1: COEF_MIN, a2: COEF_MIN};
        load_coefs(c, 1'b1);
        send_request(3'd2, SAMPLE_MAX);
        send_request(3'd2, SAMPLE_MAX);
        send_request(3'd2, SAMPLE_MAX);
        send_request(3'd2, SAMPLE_MIN);
        wait_results();

        // Zero coefficients: saturated delay words must not leak through
        c = '{b0: '0, b1: '0, b2: '0, a1: '0, a2: '0};
        load_coefs(c, 1'b0);
        send_request(3'd3, SAMPLE_MAX);
        send_request(3'd0, SAMPLE_MIN);
        wait_results();

        // Gain of one half on odd samples: exact halves round upwards
        c = '{b0: COEF_HALF, b1: '0, b2: '0, a1: '0, a2: '0};
        load_coefs(c, 1'b0);
        send_request(3'd4, 24'sd1);
        send_request(3'd5, -24'sd1);
        send_request(3'd6, 24'sd3);
        wait_results();

        // Random phases, each with its own coefficient set
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            load_coefs(pick_coefs(t_coef_mix'(p % 4)), p[0]);
            if (p == 1) rx_hold_cycles = LONG_HOLD;
            run_phase(PHASE_ITEMS);
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #15_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/mbq_pkg.sv
rtl/mbq_sequencer.sv
rtl/mbq_state_ram.sv
rtl/mbq_datapath.sv
rtl/multichannel_biquad_filter.sv
sim/mbq_filter_checker.sv
sim/tb_top.sv
